FILE: hw/rtl/dns_name_label_decoder_defines.svh
// assertion macros used by the bound checker file dnld_checker.sv
`ifndef DNS_NAME_LABEL_DECODER_DEFINES_SVH
`define DNS_NAME_LABEL_DECODER_DEFINES_SVH

// same-cycle implication
`define DNLD_ASSERT_NOW(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("dnld check failed");

// next-cycle implication
`define DNLD_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("dnld check failed");

`endif

FILE: hw/rtl/dnld_pkg.sv
`default_nettype none
package dnld_pkg;

    localparam logic [6:0] MAX_LABELS            = 7'd64;
    localparam logic [7:0] TOP_BITS              = 8'hC0;
    localparam logic [7:0] DOT_CHAR              = 8'h2E;
    localparam logic [7:0] MAX_NAME_LENGTH_RESET = 8'd253;
    localparam int         QUEUE_DEPTH           = 4;
    localparam int         QUEUE_PTR_W           = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_LEN   = 2'd1,
        PH_LABEL = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_CHAR = 2'd0,
        KIND_DONE = 2'd1,
        KIND_ERR  = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       first_byte;
        logic       packet_end;
    } in_item_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] char_value;
        logic [7:0] name_length;
        logic       run_last;
    } out_item_t;

    // results produced by one decoded byte, in order
    typedef struct packed {
        logic [1:0] count;
        out_item_t  res0;
        out_item_t  res1;
    } push_t;

endpackage
`default_nettype wire

FILE: hw/rtl/dns_name_label_decoder.sv
`default_nettype none
// path: a byte is held in the input register, decoded combinationally and its results written into
// the result queue when the queue has room; results are output from the head of the queue
// throughput: one byte per cycle while the 4-entry result queue has two free entries; a byte can give two results,
// the queue drains one result per cycle while out_ready is high, so the sustained rate follows the output side
// reset: phase idle, counters zero, max_name_length 253, queue empty; no clearing pass
module dns_name_label_decoder (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [7:0]          cfg_data,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire dnld_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output dnld_pkg::out_item_t      out_data
);
    import dnld_pkg::*;

    logic     in_valid_reg;
    in_item_t in_item_reg;
    logic     room;
    logic     take;
    push_t    push;

    assign cfg_ready = 1'b1;
    assign take      = in_valid_reg && room;
    assign in_ready  = !in_valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            in_item_reg <= in_data;
        end
    end

    dnld_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .take      (take),
        .item      (in_item_reg),
        .push      (push)
    );

    dnld_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
`default_nettype wire

FILE: hw/rtl/dnld_core.sv
`default_nettype none
module dnld_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_write,
    input  wire logic [7:0]       cfg_data,
    input  wire logic             take,
    input  wire dnld_pkg::in_item_t item,
    output dnld_pkg::push_t       push
);
    import dnld_pkg::*;

    logic [7:0] max_name_length_reg;
    phase_t     phase_reg, phase_next;
    logic [5:0] left_reg, left_next;
    logic [7:0] chars_reg, chars_next;
    logic [6:0] labels_reg, labels_next;

    logic [7:0] limit;
    phase_t     ph_e;
    logic [7:0] cw_e;
    logic [6:0] ls_e;
    logic [5:0] left_e;
    logic       has_char;
    logic [7:0] char_byte;
    logic [7:0] char_len;
    logic       has_end;
    kind_t      end_kind;
    logic [7:0] end_len;
    logic [5:0] left_dec;
    logic [7:0] cw_inc;
    logic [6:0] ls_inc;

    assign limit = (max_name_length_reg != 8'd0) ? max_name_length_reg - 8'd1 : 8'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_name_length_reg <= MAX_NAME_LENGTH_RESET;
            phase_reg           <= PH_IDLE;
            left_reg            <= '0;
            chars_reg           <= '0;
            labels_reg          <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                max_name_length_reg <= cfg_data;
            end
            if (take)
            begin
                phase_reg  <= phase_next;
                left_reg   <= left_next;
                chars_reg  <= chars_next;
                labels_reg <= labels_next;
            end
        end
    end

    always_comb
    begin
        // a first byte restarts the name
        ph_e   = item.first_byte ? PH_LEN : phase_reg;
        cw_e   = item.first_byte ? 8'd0 : chars_reg;
        ls_e   = item.first_byte ? 7'd0 : labels_reg;
        left_e = item.first_byte ? 6'd0 : left_reg;

        phase_next  = ph_e;
        left_next   = left_e;
        chars_next  = cw_e;
        labels_next = ls_e;

        has_char  = 1'b0;
        char_byte = item.byte_value;
        char_len  = 8'd0;
        has_end   = 1'b0;
        end_kind  = KIND_DONE;
        end_len   = 8'd0;
        cw_inc    = cw_e + 8'd1;
        left_dec  = left_e - 6'd1;
        ls_inc    = ls_e + 7'd1;

        case (ph_e)
            PH_LEN:
            begin
                if (cw_e >= limit || ls_e >= MAX_LABELS || item.byte_value == 8'd0
                    || (item.byte_value & TOP_BITS) != 8'd0)
                begin
                    has_end    = 1'b1;
                    end_kind   = KIND_DONE;
                    end_len    = cw_e;
                    phase_next = PH_IDLE;
                end
                else if (item.packet_end)
                begin
                    has_end    = 1'b1;
                    end_kind   = KIND_ERR;
                    end_len    = cw_e;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    // dot between labels while room is left
                    if (cw_e != 8'd0 && cw_e < limit)
                    begin
                        has_char   = 1'b1;
                        char_byte  = DOT_CHAR;
                        char_len   = cw_inc;
                        chars_next = cw_inc;
                    end
                    left_next  = item.byte_value[5:0];
                    phase_next = PH_LABEL;
                end
            end
            PH_LABEL:
            begin
                if (cw_e < limit)
                begin
                    has_char   = 1'b1;
                    char_len   = cw_inc;
                    chars_next = cw_inc;
                end
                left_next = left_dec;
                if (left_dec == 6'd0)
                begin
                    labels_next = ls_inc;
                    if (chars_next >= limit || ls_inc >= MAX_LABELS)
                    begin
                        has_end    = 1'b1;
                        end_kind   = KIND_DONE;
                        end_len    = chars_next;
                        phase_next = PH_IDLE;
                    end
                    else if (item.packet_end)
                    begin
                        has_end    = 1'b1;
                        end_kind   = KIND_ERR;
                        end_len    = chars_next;
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        phase_next = PH_LEN;
                    end
                end
                else if (item.packet_end)
                begin
                    has_end    = 1'b1;
                    end_kind   = KIND_ERR;
                    end_len    = chars_next;
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_comb
    begin
        push = '0;
        if (has_char)
        begin
            push.res0.kind        = KIND_CHAR;
            push.res0.char_value  = char_byte;
            push.res0.name_length = char_len;
            push.res0.run_last    = !has_end;
            push.res1.kind        = end_kind;
            push.res1.char_value  = 8'd0;
            push.res1.name_length = end_len;
            push.res1.run_last    = 1'b1;
            push.count            = has_end ? 2'd2 : 2'd1;
        end
        else
        begin
            push.res0.kind        = end_kind;
            push.res0.char_value  = 8'd0;
            push.res0.name_length = end_len;
            push.res0.run_last    = 1'b1;
            push.res1             = push.res0;
            push.count            = has_end ? 2'd1 : 2'd0;
        end
        if (!take)
        begin
            push.count = 2'd0;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/dnld_out_queue.sv
`default_nettype none
module dnld_out_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dnld_pkg::push_t   push,
    output logic                   room,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output dnld_pkg::out_item_t    out_data
);
    import dnld_pkg::*;

    localparam logic [QUEUE_PTR_W:0] DEPTH_C = (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);

    out_item_t              ent_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_PTR_W:0]   count_reg, count_next;
    logic [QUEUE_PTR_W-1:0] wr_ptr_1;
    logic                   pop;

    assign out_valid = count_reg != '0;
    assign out_data  = ent_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;
    // two free entries needed for the worst case of one byte
    assign room      = count_reg <= DEPTH_C - (QUEUE_PTR_W + 1)'(2);
    assign wr_ptr_1  = wr_ptr_reg + QUEUE_PTR_W'(1);

    always_comb
    begin
        count_next = count_reg + {{(QUEUE_PTR_W - 1){1'b0}}, push.count}
                     - {{QUEUE_PTR_W{1'b0}}, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            wr_ptr_reg <= wr_ptr_reg + push.count[QUEUE_PTR_W-1:0];
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            ent_reg[wr_ptr_reg] <= push.res0;
        end
        if (push.count == 2'd2)
        begin
            ent_reg[wr_ptr_1] <= push.res1;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/dnld_checker.sv
`default_nettype none
`include "dns_name_label_decoder_defines.svh"
module dnld_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire dnld_pkg::out_item_t out_data
);
    import dnld_pkg::*;

    // a stalled result holds
    `DNLD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

    // only character results carry a character
    `DNLD_ASSERT_NOW(a_char_zero, clk, rst_n, out_valid && out_data.kind != KIND_CHAR, out_data.char_value == 8'd0)

    // a character result always counts itself
    `DNLD_ASSERT_NOW(a_char_len, clk, rst_n, out_valid && out_data.kind == KIND_CHAR, out_data.name_length != 8'd0)

    // completion and error results close the run of a byte
    `DNLD_ASSERT_NOW(a_end_last, clk, rst_n, out_valid && out_data.kind != KIND_CHAR, out_data.run_last)

endmodule

bind dns_name_label_decoder dnld_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
`default_nettype wire

FILE: verif/dns_name_label_decoder_checker.sv
module dns_name_label_decoder_checker
    import dnld_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_valid,
    input  logic       cfg_ready,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    input  logic       in_ready,
    input  in_item_t   in_data,
    input  logic       out_valid,
    input  logic       out_ready,
    input  out_item_t  out_data,
    output int         errors,
    output int         pending
);

    phase_t     ph;
    logic [5:0] label_left;
    logic [7:0] n_chars;
    logic [6:0] n_labels;
    logic [7:0] name_cap;

    out_item_t  due_results[$];
    out_item_t  step_res[2];
    int         step_n;
    int         n_fail = 0;
    int         n_due = 0;

    assign errors  = n_fail;
    assign pending = n_due;

    function automatic logic [7:0] copy_limit();
        return (name_cap >= 8'd1) ? name_cap - 8'd1 : 8'd0;
    endfunction

    function automatic logic name_full();
        return (n_chars >= copy_limit()) || (n_labels >= MAX_LABELS);
    endfunction

    task report(input string msg);
        n_fail++;
        if (n_fail <= 100)
            $display("mismatch: %s", msg);
    endtask

    task add_result(input kind_t k, input logic [7:0] ch);
        step_res[step_n].kind        = k;
        step_res[step_n].char_value  = ch;
        step_res[step_n].name_length = n_chars;
        step_res[step_n].run_last    = 1'b0;
        step_n++;
    endtask

    task decode_byte(input in_item_t it);
        step_n = 0;
        if (it.first_byte)
        begin
            ph         = PH_LEN;
            label_left = '0;
            n_chars    = '0;
            n_labels   = '0;
        end
        case (ph)
            PH_LEN:
            begin
                if (name_full() || it.byte_value == 8'd0 || (it.byte_value & TOP_BITS) != 8'd0)
                begin
                    add_result(KIND_DONE, 8'd0);
                    ph = PH_IDLE;
                end
                else if (it.packet_end)
                begin
                    add_result(KIND_ERR, 8'd0);
                    ph = PH_IDLE;
                end
                else
                begin
                    // dot only between labels and only while there is room
                    if (n_chars > 8'd0 && n_chars < copy_limit())
                    begin
                        n_chars = n_chars + 8'd1;
                        add_result(KIND_CHAR, DOT_CHAR);
                    end
                    label_left = it.byte_value[5:0];
                    ph         = PH_LABEL;
                end
            end
            PH_LABEL:
            begin
                if (n_chars < copy_limit())
                begin
                    n_chars = n_chars + 8'd1;
                    add_result(KIND_CHAR, it.byte_value);
                end
                label_left = label_left - 6'd1;
                if (label_left == 6'd0)
                begin
                    n_labels = n_labels + 7'd1;
                    if (name_full())
                    begin
                        add_result(KIND_DONE, 8'd0);
                        ph = PH_IDLE;
                    end
                    else if (it.packet_end)
                    begin
                        add_result(KIND_ERR, 8'd0);
                        ph = PH_IDLE;
                    end
                    else
                    begin
                        ph = PH_LEN;
                    end
                end
                else if (it.packet_end)
                begin
                    add_result(KIND_ERR, 8'd0);
                    ph = PH_IDLE;
                end
            end
            default:
            begin
            end
        endcase
        if (step_n > 0)
            step_res[step_n - 1].run_last = 1'b1;
        for (int i = 0; i < step_n; i++)
            due_results.push_back(step_res[i]);
    endtask

    task check_result(input out_item_t got);
        out_item_t want;
        if (due_results.size() == 0)
        begin
            report($sformatf("result with nothing due: kind %0d char %02h len %0d",
                             got.kind, got.char_value, got.name_length));
        end
        else
        begin
            want = due_results.pop_front();
            if (got.kind !== want.kind)
                report($sformatf("kind: want %0d got %0d", want.kind, got.kind));
            if (got.char_value !== want.char_value)
                report($sformatf("char_value: want %02h got %02h",
                                 want.char_value, got.char_value));
            if (got.name_length !== want.name_length)
                report($sformatf("name_length: want %0d got %0d",
                                 want.name_length, got.name_length));
            if (got.run_last !== want.run_last)
                report($sformatf("run_last: want %0b got %0b", want.run_last, got.run_last));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph         = PH_IDLE;
            label_left = '0;
            n_chars    = '0;
            n_labels   = '0;
            name_cap   = MAX_NAME_LENGTH_RESET;
            due_results.delete();
            n_due      = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                name_cap = cfg_data;
            if (in_valid && in_ready)
                decode_byte(in_data);
            if (out_valid && out_ready)
                check_result(out_data);
            n_due = due_results.size();
        end
    end

endmodule

FILE: verif/tb.sv
module tb;
    import dnld_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 265;

    logic      clk;
    logic      rst_n;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [7:0] cfg_data;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;

    int        errors;
    int        pending;
    int        cycles = 0;
    int        sent = 0;
    int        snd_idle = 0;
    int        rcv_idle = 0;
    int        hold_left = 0;
    bit        rcv_hold_req = 0;
    logic      in_took = 1'b0;
    logic      cfg_took = 1'b0;

    dns_name_label_decoder u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    dns_name_label_decoder_checker u_chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // transfers seen at the rising edge, read back at the next falling edge
    always @(posedge clk)
    begin
        in_took  <= in_valid && in_ready;
        cfg_took <= cfg_valid && cfg_ready;
        cycles   <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rcv_hold_req)
            begin
                rcv_hold_req = 0;
                hold_left    = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= rcv_idle);
            end
        end
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic push_byte(input logic [7:0] b, input logic first, input logic last);
        while ($urandom_range(0, 99) < snd_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid           <= 1'b1;
        in_data.byte_value <= b;
        in_data.first_byte <= first;
        in_data.packet_end <= last;
        do
            @(negedge clk);
        while (!in_took);
        sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_limit(input logic [7:0] v);
        wait_drained();
        // a byte with no result may still be in flight
        repeat (8) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(negedge clk);
        while (!cfg_took);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] end_marker();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return 8'h00;
        else if (r < 90)
            return 8'hC0 | 8'($urandom_range(0, 63));
        else if (r < 95)
            return 8'h40 | 8'($urandom_range(0, 63));
        else
            return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    task automatic send_name();
        int r;
        int nlab;
        int len;
        int l;
        int i;
        bit stop;
        r    = $urandom_range(0, 99);
        stop = 0;
        if (r < 72)
        begin
            // well-formed name, sometimes long enough to hit the label count limit
            nlab = ($urandom_range(0, 24) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 5);
            for (l = 0; l < nlab && !stop; l++)
            begin
                if (nlab > 8)
                    len = $urandom_range(1, 2);
                else if ($urandom_range(0, 7) == 0)
                    len = $urandom_range(1, 63);
                else
                    len = $urandom_range(1, 8);
                push_byte(len[7:0], l == 0, 1'b0);
                for (i = 0; i < len && !stop; i++)
                begin
                    if ($urandom_range(0, 199) == 0)
                    begin
                        push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b1);
                        stop = 1;
                    end
                    else
                    begin
                        push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                    end
                end
            end
            if (!stop)
                push_byte(end_marker(), 1'b0, 1'($urandom_range(0, 1)));
        end
        else if (r < 88)
        begin
            push_byte(8'($urandom_range(0, 255)), 1'b1, $urandom_range(0, 3) == 0);
            repeat ($urandom_range(0, 6))
                push_byte(8'($urandom_range(0, 255)), 1'b0, $urandom_range(0, 3) == 0);
        end
        else
        begin
            repeat ($urandom_range(1, 4))
                push_byte(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        int limits[6];
        int start;
        int p;
        bit disturbed;

        rst_n     = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        in_data   = '0;
        limits    = '{254, 2, 37, 0, 6, 253};
        limits[3] = $urandom_range(2, 254);

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed names at the reset limit
        push_byte(8'd1, 1'b1, 1'b0);
        push_byte("a", 1'b0, 1'b0);
        push_byte(8'd0, 1'b0, 1'b0);
        push_byte(8'hC0, 1'b1, 1'b0);
        push_byte(8'h40, 1'b1, 1'b0);
        push_byte(8'h80, 1'b1, 1'b0);
        push_byte(8'h41, 1'b0, 1'b0);       // idle byte, ignored
        push_byte(8'd3, 1'b1, 1'b1);        // length byte at packet end
        push_byte(8'd2, 1'b1, 1'b0);
        push_byte("x", 1'b0, 1'b1);         // packet ends inside the label
        push_byte(8'd1, 1'b1, 1'b0);
        push_byte("y", 1'b0, 1'b1);         // last label byte at packet end
        push_byte(8'd2, 1'b1, 1'b0);
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b0);
        push_byte(8'd1, 1'b0, 1'b0);
        push_byte(8'h7F, 1'b0, 1'b0);
        push_byte(8'h00, 1'b0, 1'b1);
        push_byte(8'd5, 1'b1, 1'b0);
        push_byte("q", 1'b0, 1'b0);
        push_byte(8'h00, 1'b1, 1'b0);       // new name drops the one in progress

        for (p = 0; p < 6; p++)
        begin
            case (p / 2)
                0:
                begin
                    snd_idle = 14;
                    rcv_idle = 82;
                end
                1:
                begin
                    snd_idle = 82;
                    rcv_idle = 14;
                end
                default:
                begin
                    snd_idle = 0;
                    rcv_idle = 0;
                end
            endcase

            // leave a label open across the register write
            push_byte(8'd10, 1'b1, 1'b0);
            repeat (4) push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            write_limit(limits[p][7:0]);
            repeat (5) push_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            push_byte(8'd0, 1'b0, 1'b0);

            start     = sent;
            disturbed = 0;
            while (sent - start < PHASE_ITEMS)
            begin
                send_name();
                if (!disturbed && sent - start >= PHASE_ITEMS / 2)
                begin
                    disturbed = 1;
                    if (p == 4)
                        rcv_hold_req = 1;
                    else if (p == 5)
                        wait_drained();
                end
            end
        end

        wait_drained();
        repeat (20) @(negedge clk);
        if (errors == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
